>>> design/btop_pkg.sv
// Shared types, constants and codes for the binomial tree option pricer.
`timescale 1ns / 1ps

package btop_pkg;

  localparam int MAX_STEPS = 1024;
  localparam int NODE_CAP  = MAX_STEPS + 1;
  localparam int ADDR_W    = $clog2(NODE_CAP);
  localparam int CNT_W     = $clog2(NODE_CAP + 1);
  localparam int PRICE_W   = 32;
  localparam int PROB_W    = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(65536);

  typedef logic [PRICE_W-1:0] price_t;
  typedef logic [PROB_W-1:0]  prob_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [1:0] {
    KIND_CALL = 2'd0,
    KIND_PUT  = 2'd1,
    KIND_BULL = 2'd2,
    KIND_BEAR = 2'd3
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_OPTION_KIND     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIKE_LOW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIKE_HIGH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_PROBABILITY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT_FACTOR = 3'd4;

  typedef struct packed {
    logic   valid;
    price_t up;
    price_t down;
    addr_t  addr;
  } step_req_t;

  typedef struct packed {
    logic   busy;
    logic   we;
    addr_t  addr;
    price_t data;
  } step_rsp_t;

endpackage

>>> design/btop_payoff.sv
// Payoff of one terminal price for call, put, bull spread and bear spread.
`timescale 1ns / 1ps

module btop_payoff (
  input  btop_pkg::kind_t  kind,
  input  btop_pkg::price_t strike_low,
  input  btop_pkg::price_t strike_high,
  input  btop_pkg::price_t price,
  output btop_pkg::price_t payoff
);
  import btop_pkg::*;

  price_t spread_width;

  assign spread_width = (strike_high > strike_low) ? strike_high - strike_low : '0;

  always_comb begin
    unique case (kind)
      KIND_CALL: begin
        payoff = (price > strike_low) ? price - strike_low : '0;
      end
      KIND_PUT: begin
        payoff = (strike_low > price) ? strike_low - price : '0;
      end
      KIND_BULL: begin
        if (price <= strike_low) begin
          payoff = '0;
        end else if (price < strike_high) begin
          payoff = price - strike_low;
        end else begin
          payoff = spread_width;
        end
      end
      KIND_BEAR: begin
        if (price <= strike_low) begin
          payoff = spread_width;
        end else if (price < strike_high) begin
          payoff = strike_high - price;
        end else begin
          payoff = '0;
        end
      end
      default: payoff = '0;
    endcase
  end

endmodule

>>> design/btop_node_ram.sv
// Simple dual-port node memory with one write port and a registered read port.
`timescale 1ns / 1ps

module btop_node_ram #(
  parameter int DEPTH = 1025,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/btop_step.sv
// Pipelined induction step: weighted mean of two nodes, then discounting.
`timescale 1ns / 1ps

module btop_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  btop_pkg::prob_t      q,
  input  btop_pkg::prob_t      d,
  input  btop_pkg::step_req_t  req,
  output btop_pkg::step_rsp_t  rsp
);
  import btop_pkg::*;

  localparam int PROD_W = PROB_W + PRICE_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int M_W    = SUM_W - 16;
  localparam int V_W    = M_W + PROB_W;
  localparam int SH_W   = V_W - 16;

  prob_t             q_comp;
  logic              a_valid_r;
  logic [PROD_W-1:0] prod_up_r;
  logic [PROD_W-1:0] prod_down_r;
  addr_t             a_addr_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [M_W-1:0]    mean_nxt;
  logic [V_W-1:0]    disc_nxt;
  logic              b_valid_r;
  logic [V_W-1:0]    disc_r;
  addr_t             b_addr_r;
  logic [SH_W-1:0]   shifted;

  assign q_comp = ONE_Q16 - q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= req.valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_up_r   <= {{PRICE_W{1'b0}}, q} * {{PROB_W{1'b0}}, req.up};
    prod_down_r <= {{PRICE_W{1'b0}}, q_comp} * {{PROB_W{1'b0}}, req.down};
    a_addr_r    <= req.addr;
    disc_r      <= disc_nxt;
    b_addr_r    <= a_addr_r;
  end

  assign sum_nxt  = {1'b0, prod_up_r} + {1'b0, prod_down_r};
  assign mean_nxt = sum_nxt[SUM_W-1:16];
  assign disc_nxt = {{PROB_W{1'b0}}, mean_nxt} * {{M_W{1'b0}}, d};
  assign shifted  = disc_r[V_W-1:16];

  always_comb begin
    rsp.busy = a_valid_r | b_valid_r;
    rsp.we   = b_valid_r;
    rsp.addr = b_addr_r;
    rsp.data = (|shifted[SH_W-1:PRICE_W]) ? '1 : shifted[PRICE_W-1:0];
  end

endmodule

>>> design/binomial_tree_option_pricer.sv
// Top level of the binomial tree option pricer: control, configuration and node memory.
// An item that does not mark the last price is taken while busy is low, one item per cycle.
// With N stored nodes, the last item keeps busy high while each of the N-1 levels streams
// its nodes through the one node memory read port and then drains the read and step
// pipeline. The strobed result appears as busy falls.
// Reset (synchronous, active low) clears node count, state, valid flags and config, not memory.
`timescale 1ns / 1ps

module binomial_tree_option_pricer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  btop_pkg::price_t              in_terminal_price,
  input  logic                          in_is_last,
  output logic                          out_valid,
  output btop_pkg::price_t              out_option_price,
  input  logic                          cfg_we,
  input  logic [btop_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [btop_pkg::CFG_W-1:0]     cfg_data
);
  import btop_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_READ  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_ROOT  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t    state_r, state_nxt;
  kind_t     kind_r;
  price_t    strike_low_r, strike_high_r;
  prob_t     up_prob_r, discount_r;
  prob_t     q_use, d_use;
  cnt_t      cnt_r, cnt_nxt, cnt_stored;
  addr_t     lvl_r, lvl_nxt;
  addr_t     addr_r, addr_nxt;
  logic      accept, store;
  price_t    payoff;
  logic      mem_we, rd_en;
  addr_t     mem_waddr, rd_addr;
  price_t    mem_wdata, rdata;
  logic      dv_r, first_r;
  addr_t     rd_idx_r;
  price_t    prev_r;
  logic      out_valid_r;
  price_t    out_price_r;
  step_req_t step_req;
  step_rsp_t step_rsp;

  assign busy   = (state_r != S_LOAD);
  assign accept = start && !busy;
  assign store  = accept && (cnt_r < CNT_W'(NODE_CAP));
  assign q_use  = (up_prob_r > ONE_Q16) ? ONE_Q16 : up_prob_r;
  assign d_use  = (discount_r > ONE_Q16) ? ONE_Q16 : discount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r        <= KIND_CALL;
      strike_low_r  <= '0;
      strike_high_r <= '0;
      up_prob_r     <= PROB_W'(32768);
      discount_r    <= ONE_Q16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OPTION_KIND:     kind_r        <= kind_t'(cfg_data[1:0]);
        CFG_STRIKE_LOW:      strike_low_r  <= cfg_data[PRICE_W-1:0];
        CFG_STRIKE_HIGH:     strike_high_r <= cfg_data[PRICE_W-1:0];
        CFG_UP_PROBABILITY:  up_prob_r     <= cfg_data[PROB_W-1:0];
        CFG_DISCOUNT_FACTOR: discount_r    <= cfg_data[PROB_W-1:0];
        default: ;
      endcase
    end
  end

  btop_payoff u_payoff (
    .kind        (kind_r),
    .strike_low  (strike_low_r),
    .strike_high (strike_high_r),
    .price       (in_terminal_price),
    .payoff      (payoff)
  );

  assign cnt_stored = store ? cnt_r + 1'b1 : cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    lvl_nxt   = lvl_r;
    addr_nxt  = addr_r;
    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          cnt_nxt = cnt_stored;
          if (in_is_last) begin
            cnt_nxt  = '0;
            lvl_nxt  = ADDR_W'(cnt_stored - 1'b1);
            addr_nxt = '0;
            state_nxt = (cnt_stored == CNT_W'(1)) ? S_ROOT : S_READ;
          end
        end
      end
      S_READ: begin
        if (addr_r == lvl_r) begin
          state_nxt = S_DRAIN;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!dv_r && !step_rsp.busy) begin
          if (lvl_r == ADDR_W'(1)) begin
            state_nxt = S_ROOT;
          end else begin
            lvl_nxt   = lvl_r - 1'b1;
            addr_nxt  = '0;
            state_nxt = S_READ;
          end
        end
      end
      S_ROOT:  state_nxt = S_EMIT;
      S_EMIT:  state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dv_r        <= rd_en;
      out_valid_r <= (state_r == S_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    lvl_r    <= lvl_nxt;
    addr_r   <= addr_nxt;
    first_r  <= (rd_addr == '0);
    rd_idx_r <= rd_addr;
    if (dv_r) begin
      prev_r <= rdata;
    end
    if (state_r == S_EMIT) begin
      out_price_r <= rdata;
    end
  end

  assign rd_en   = (state_r == S_READ) || (state_r == S_ROOT);
  assign rd_addr = (state_r == S_ROOT) ? '0 : addr_r;

  always_comb begin
    if (store) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_r[ADDR_W-1:0];
      mem_wdata = payoff;
    end else begin
      mem_we    = step_rsp.we;
      mem_waddr = step_rsp.addr;
      mem_wdata = step_rsp.data;
    end
  end

  btop_node_ram #(
    .DEPTH (NODE_CAP),
    .WIDTH (PRICE_W)
  ) u_node_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_comb begin
    step_req.valid = dv_r && !first_r && (state_r != S_EMIT);
    step_req.up    = rdata;
    step_req.down  = prev_r;
    step_req.addr  = rd_idx_r - 1'b1;
  end

  btop_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .q     (q_use),
    .d     (d_use),
    .req   (step_req),
    .rsp   (step_rsp)
  );

  assign out_valid        = out_valid_r;
  assign out_option_price = out_price_r;

endmodule

>>> design/btop_checker.sv
// Port-level checks for the binomial tree option pricer and their binding.
`timescale 1ns / 1ps

module btop_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_is_last,
  input logic out_valid
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_is_last) |=> !busy)
    else $error("busy raised by an item that is not the last");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_is_last) |=> busy)
    else $error("last item did not start the backward pass");

  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("backward pass ended without a result");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

endmodule

bind binomial_tree_option_pricer btop_checker u_btop_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_is_last (in_is_last),
  .out_valid  (out_valid)
);
